[hdl/hte_pkg.sv]
package hte_pkg;

  typedef struct packed {
    logic [15:0] char_code;
    logic        start_of_text;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_code;
    logic        last_of_run;
  } out_item_t;

  localparam logic [2:0] KIND_CHAR = 3'd0;
  localparam logic [2:0] KIND_AMP  = 3'd1;
  localparam logic [2:0] KIND_LT   = 3'd2;
  localparam logic [2:0] KIND_GT   = 3'd3;
  localparam logic [2:0] KIND_QUOT = 3'd4;
  localparam logic [2:0] KIND_BR   = 3'd5;
  localparam logic [2:0] KIND_BRX  = 3'd6;
  localparam logic [2:0] KIND_NBSP = 3'd7;

  localparam logic [15:0] CODE_CR    = 16'h000D;
  localparam logic [15:0] CODE_LF    = 16'h000A;
  localparam logic [15:0] CODE_SPACE = 16'h0020;
  localparam logic [15:0] CODE_AMP   = 16'h0026;
  localparam logic [15:0] CODE_LT    = 16'h003C;
  localparam logic [15:0] CODE_GT    = 16'h003E;
  localparam logic [15:0] CODE_QUOT  = 16'h0022;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] code;
  } q_entry_t;

  function automatic logic [2:0] seq_len(input logic [2:0] kind);
    logic [2:0] len;
    case (kind)
      KIND_CHAR: len = 3'd1;
      KIND_AMP:  len = 3'd5;
      KIND_LT:   len = 3'd4;
      KIND_GT:   len = 3'd4;
      KIND_QUOT: len = 3'd6;
      KIND_BR:   len = 3'd5;
      KIND_BRX:  len = 3'd6;
      KIND_NBSP: len = 3'd6;
      default:   len = 3'd1;
    endcase
    return len;
  endfunction

  function automatic logic [15:0] seq_char(input logic [2:0] kind, input logic [2:0] idx,
                                           input logic [15:0] code);
    logic [47:0] s;
    logic [7:0]  b;
    case (kind)
      KIND_AMP:  s = {"&amp;", 8'h00};
      KIND_LT:   s = {"&lt;", 16'h0000};
      KIND_GT:   s = {"&gt;", 16'h0000};
      KIND_QUOT: s = "&quot;";
      KIND_BR:   s = {"<br>", 8'h0A, 8'h00};
      KIND_BRX:  s = {"<br/>", 8'h0A};
      KIND_NBSP: s = "&nbsp;";
      default:   s = 48'h0;
    endcase
    case (idx)
      3'd0:    b = s[47:40];
      3'd1:    b = s[39:32];
      3'd2:    b = s[31:24];
      3'd3:    b = s[23:16];
      3'd4:    b = s[15:8];
      3'd5:    b = s[7:0];
      default: b = 8'h00;
    endcase
    if (kind == KIND_CHAR) begin
      return code;
    end
    return {8'h00, b};
  endfunction

endpackage

[hdl/hte_front.sv]
module hte_front
  import hte_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_we,
  input  logic     cfg_data,
  input  logic     in_valid,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     in_stall,
  output logic     push,
  output q_entry_t push_entry
);

  logic html_mode;
  logic prev_was_space;
  logic prev_was_space_next;
  logic accept;
  logic run_live;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign run_live = prev_was_space && !in_data.start_of_text;

  always_comb begin
    push                = accept && (in_data.char_code != CODE_CR);
    push_entry.code     = in_data.char_code;
    push_entry.kind     = KIND_CHAR;
    prev_was_space_next = 1'b0;
    case (in_data.char_code)
      CODE_CR: begin
        prev_was_space_next = run_live;
      end
      CODE_SPACE: begin
        prev_was_space_next = 1'b1;
        if (run_live) begin
          push_entry.kind = KIND_NBSP;
        end
      end
      CODE_AMP:  push_entry.kind = KIND_AMP;
      CODE_LT:   push_entry.kind = KIND_LT;
      CODE_GT:   push_entry.kind = KIND_GT;
      CODE_QUOT: push_entry.kind = KIND_QUOT;
      CODE_LF:   push_entry.kind = html_mode ? KIND_BR : KIND_BRX;
      default:   push_entry.kind = KIND_CHAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      html_mode      <= 1'b0;
      prev_was_space <= 1'b0;
    end else begin
      if (cfg_we) begin
        html_mode <= cfg_data;
      end
      if (accept) begin
        prev_was_space <= prev_was_space_next;
      end
    end
  end

endmodule

[hdl/hte_queue.sv]
module hte_queue
  import hte_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t push_entry,
  input  logic     pop,
  output logic     full,
  output logic     q_valid,
  output q_entry_t q_entry
);

  q_entry_t          mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full    = (count == (QPTR_W+1)'(QDEPTH));
  assign q_valid = (count != '0);
  assign q_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hdl/hte_back.sv]
module hte_back
  import hte_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  q_entry_t  q_entry,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic [2:0] idx;
  logic       load;
  logic       last;

  assign load = !out_valid || !out_stall;
  assign last = (idx == seq_len(q_entry.kind) - 3'd1);
  assign pop  = load && q_valid && last;

  always_ff @(posedge clk) begin
    if (load && q_valid) begin
      out_data.out_code    <= seq_char(q_entry.kind, idx, q_entry.code);
      out_data.last_of_run <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= q_valid;
      if (q_valid) begin
        idx <= last ? 3'd0 : idx + 3'd1;
      end
    end
  end

endmodule

[hdl/html_text_escaper.sv]
// An accepted character is written into the queue and then into the output register.
// The output register sends one escaped code unit per cycle unless the receiver stalls;
// a character escapes to one to six code units, and a carriage return produces none.
// A four-entry queue lets the input side run ahead while a long escape drains.
// Synchronous reset clears the mode register, the space run, the queue and the output.
module html_text_escaper
  import hte_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_data,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic     push;
  q_entry_t push_entry;
  logic     q_full;
  logic     q_valid;
  q_entry_t q_entry;
  logic     pop;

  hte_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .q_full     (q_full),
    .in_stall   (in_stall),
    .push       (push),
    .push_entry (push_entry)
  );

  hte_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .q_valid    (q_valid),
    .q_entry    (q_entry)
  );

  hte_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[sim/html_text_escaper_tb.sv]
`timescale 1ns / 100ps

module html_text_escaper_tb;
  import hte_pkg::*;

  localparam int        TAIL_CYCLES  = 24;
  localparam int        HOLD_CYCLES  = 300;
  localparam int        RUN_MAX      = 6;
  localparam logic [15:0] CODE_UPPER_A = 16'h0041;
  localparam logic [15:0] CODE_LOWER_X = 16'h0078;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_we = 1'b0;
  logic      cfg_data = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  out_item_t expected_units[$];
  logic      space_run = 1'b0;
  logic      br_html = 1'b0;
  int        fail_count = 0;

  int stall_pct = 0;
  int gap_max = 0;
  int burst_max = 12;
  int burst_left = 0;
  int hold_request = 0;
  int hold_left = 0;
  int run_left = 0;
  logic stall_phase = 1'b0;

  html_text_escaper u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic void push_units(input string s);
    out_item_t unit;
    for (int k = 0; k < s.len(); k++) begin
      unit.out_code = {8'h00, s[k]};
      unit.last_of_run = (k == s.len() - 1);
      expected_units.push_back(unit);
    end
  endfunction

  function automatic void escape_char(input in_item_t item);
    out_item_t unit;
    if (item.start_of_text) begin
      space_run = 1'b0;
    end
    if (item.char_code == CODE_CR) begin
      return;
    end
    if (item.char_code == CODE_SPACE) begin
      if (space_run) begin
        push_units("&nbsp;");
      end else begin
        space_run = 1'b1;
        push_units(" ");
      end
      return;
    end
    space_run = 1'b0;
    case (item.char_code)
      CODE_AMP:  push_units("&amp;");
      CODE_LT:   push_units("&lt;");
      CODE_GT:   push_units("&gt;");
      CODE_QUOT: push_units("&quot;");
      CODE_LF: begin
        if (br_html) begin
          push_units("<br>\n");
        end else begin
          push_units("<br/>\n");
        end
      end
      default: begin
        unit.out_code = item.char_code;
        unit.last_of_run = 1'b1;
        expected_units.push_back(unit);
      end
    endcase
  endfunction

  function automatic logic [15:0] random_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return CODE_AMP;
    if (r < 14) return CODE_LT;
    if (r < 20) return CODE_GT;
    if (r < 26) return CODE_QUOT;
    if (r < 34) return CODE_LF;
    if (r < 42) return CODE_CR;
    if (r < 62) return CODE_SPACE;
    if (r < 85) return 16'($urandom_range(16'h0021, 16'h007E));
    return 16'($urandom);
  endfunction

  // Receiver: random runs of stall or accept, overridden by a long hold-off.
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      if (run_left == 0) begin
        stall_phase = ($urandom_range(0, 99) < stall_pct);
        run_left = $urandom_range(1, RUN_MAX);
      end
      run_left--;
      out_stall <= stall_phase;
    end
  end

  always @(posedge clk) begin : check_units
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_units.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("unexpected transaction: code %h last %b",
                   out_data.out_code, out_data.last_of_run);
        end
      end else begin
        want = expected_units.pop_front();
        if (out_data.out_code !== want.out_code ||
            out_data.last_of_run !== want.last_of_run) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch: expected code %h last %b, got code %h last %b",
                     want.out_code, want.last_of_run,
                     out_data.out_code, out_data.last_of_run);
          end
        end
      end
    end
  end

  task automatic send_char(input logic [15:0] code, input logic sot);
    in_item_t item;
    int gap;
    item.char_code = code;
    item.start_of_text = sot;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, burst_max);
      if (gap_max > 0) begin
        gap = $urandom_range(1, gap_max);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
    escape_char(item);
  endtask

  task automatic drain_units();
    in_valid <= 1'b0;
    while (expected_units.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input logic mode);
    drain_units();
    cfg_we <= 1'b1;
    cfg_data <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
    br_html = mode;
  endtask

  task automatic test_default_mode();
    send_char(CODE_LF, 1'b1);
    send_char(CODE_UPPER_A, 1'b0);
  endtask

  task automatic test_escapes();
    send_char(CODE_AMP, 1'b0);
    send_char(CODE_LT, 1'b0);
    send_char(CODE_GT, 1'b0);
    send_char(CODE_QUOT, 1'b0);
    send_char(CODE_LF, 1'b0);
  endtask

  task automatic test_space_runs();
    send_char(CODE_SPACE, 1'b1);
    send_char(CODE_SPACE, 1'b0);
    send_char(CODE_CR, 1'b0);
    send_char(CODE_SPACE, 1'b0);
    send_char(CODE_LOWER_X, 1'b0);
    send_char(CODE_SPACE, 1'b0);
    send_char(CODE_SPACE, 1'b1);
    send_char(CODE_SPACE, 1'b0);
    send_char(CODE_CR, 1'b1);
    send_char(CODE_SPACE, 1'b0);
    send_char(CODE_AMP, 1'b0);
    send_char(CODE_SPACE, 1'b0);
  endtask

  task automatic test_extremes();
    send_char(16'h0000, 1'b0);
    send_char(16'hFFFF, 1'b1);
    send_char(16'h8000, 1'b0);
    send_char(16'h7FFF, 1'b0);
  endtask

  task automatic test_mode_switch();
    set_mode(1'b1);
    send_char(CODE_LF, 1'b0);
    set_mode(1'b0);
    send_char(CODE_LF, 1'b0);
  endtask

  task automatic test_backpressure();
    drain_units();
    stall_pct = 0;
    gap_max = 0;
    burst_left = 0;
    hold_request = HOLD_CYCLES;
    for (int k = 0; k < 40; k++) begin
      send_char(($urandom_range(0, 1) == 0) ? CODE_QUOT : random_code(), k == 0);
    end
    drain_units();
  endtask

  task automatic test_random(input int n_items, input logic mode, input int pct,
                             input int gmax);
    int sent;
    int len;
    logic sot;
    set_mode(mode);
    stall_pct = pct;
    gap_max = gmax;
    burst_left = 0;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, 20);
      for (int k = 0; k < len; k++) begin
        sot = (k == 0) || ($urandom_range(0, 19) == 0);
        send_char(random_code(), sot);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_mode();
    test_escapes();
    test_space_runs();
    test_extremes();
    test_mode_switch();
    test_random(80, 1'b1, 30, 4);
    test_random(80, 1'b0, 0, 0);
    test_backpressure();
    test_random(80, 1'b1, 60, 2);
    test_random(80, 1'b0, 15, 8);
    drain_units();
    if (fail_count == 0 && expected_units.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
